// ----- hdl/irt_pkg.sv -----
// Shared types and codes for the indexed record table.
// Holds command and status codes and the input and result beat structs.
// No dependencies.
package irt_pkg;

    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int RID_W    = 32;
    localparam int HEARD_W  = 16;
    localparam int RPAY_W   = 64;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 4;
    localparam int FCOUNT_W = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LEAST  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CAP      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FILL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot_index;
        logic [RID_W-1:0]   record_id;
        logic [HEARD_W-1:0] heard_count_in;
        logic [RPAY_W-1:0]  record_payload;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_index;
        logic [FCOUNT_W-1:0] fill_count;
    } out_beat_t;

endpackage

// ----- hdl/indexed_record_table.sv -----
// Top level of the indexed record table: sequencer, record memory, result register.
// Depends on irt_pkg for command and status codes and the beat structs.
//
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   irt_pkg::in_beat_t  (one command per beat)
// m_        out        m_valid / m_ready   irt_pkg::out_beat_t (one result per command)
//
// Write, append and unknown commands pass through S_EXEC and S_RESP to the result.
// Remove, find and least-heard walk the record memory one entry per cycle through
// its single read port; remove starts at the entry after slot_index.
// Reset (aresetn low, synchronous) empties the table; memory contents are not cleared,
// and only entries below the fill count are ever read.
// A result waiting in the output register holds the sequencer before it loads the
// next result; s_ready is high only while the sequencer is idle.
module indexed_record_table #(
    parameter int CAPACITY      = 16,
    parameter int ID_WIDTH      = 32,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  irt_pkg::in_beat_t     s_beat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output irt_pkg::out_beat_t    m_beat
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > irt_pkg::SLOT_W) ? FILL_W : irt_pkg::SLOT_W;
    localparam int HW     = irt_pkg::HEARD_W;
    localparam int REC_W  = ID_WIDTH + HW + PAYLOAD_WIDTH;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    // record layout in memory: {id, heard, payload}
    logic [REC_W-1:0] rec_mem [CAPACITY];

    logic [1:0]                   state_reg, state_next;
    logic [irt_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [irt_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [ID_WIDTH-1:0]          key_reg, key_next;
    logic [HW-1:0]                heard_reg, heard_next;
    logic [PAYLOAD_WIDTH-1:0]     pay_reg, pay_next;
    logic [FILL_W-1:0]            fill_reg, fill_next;
    logic [FILL_W-1:0]            scan_reg, scan_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]             rd_addr_reg, rd_addr_next;
    logic [REC_W-1:0]             rd_data_reg;
    logic                         hit_reg, hit_next;
    logic [IDX_W-1:0]             found_reg, found_next;
    logic [HW-1:0]                least_reg, least_next;
    logic [irt_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         m_valid_reg, m_valid_next;
    irt_pkg::out_beat_t           m_beat_reg, m_beat_next;

    // memory port controls
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wr_idx;
    logic [REC_W-1:0]     mem_wr_data;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_rd_idx;

    // decode helpers
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     slot_ext;
    logic [CMP_W-1:0]     fill_ext;
    logic [CMP_W-1:0]     cap_ext;
    logic [ID_WIDTH-1:0]  rd_id;
    logic [HW-1:0]        rd_heard;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    assign slot_ext = CMP_W'(slot_reg);
    assign fill_ext = CMP_W'(fill_reg);
    assign cap_ext  = CMP_W'(CAPACITY);
    assign pos_ext  = (cmd_reg == irt_pkg::CMD_WRITE) ? slot_ext : fill_ext;

    assign rd_id    = rd_data_reg[REC_W-1 -: ID_WIDTH];
    assign rd_heard = rd_data_reg[PAYLOAD_WIDTH +: HW];

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        slot_next     = slot_reg;
        key_next      = key_reg;
        heard_next    = heard_reg;
        pay_next      = pay_reg;
        fill_next     = fill_reg;
        scan_next     = scan_reg;
        rd_valid_next = 1'b0;
        rd_addr_next  = rd_addr_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        least_next    = least_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_beat_next   = m_beat_reg;
        mem_we        = 1'b0;
        mem_wr_idx    = pos_ext[IDX_W-1:0];
        mem_wr_data   = {key_reg, heard_reg, pay_reg};
        mem_re        = 1'b0;
        mem_rd_idx    = scan_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                // latch the command beat and clear the per-command result
                if (s_valid) begin
                    cmd_next    = s_beat.cmd;
                    slot_next   = s_beat.slot_index;
                    key_next    = ID_WIDTH'(s_beat.record_id);
                    heard_next  = s_beat.heard_count_in;
                    pay_next    = PAYLOAD_WIDTH'(s_beat.record_payload);
                    hit_next    = 1'b0;
                    found_next  = '0;
                    status_next = irt_pkg::ST_OK;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC: begin
                case (cmd_reg) inside
                    irt_pkg::CMD_WRITE, irt_pkg::CMD_APPEND: begin
                        // check bounds, then store and grow on a write at the end
                        state_next = S_RESP;
                        if (pos_ext >= cap_ext) begin
                            status_next = irt_pkg::ST_CAP;
                        end else if (pos_ext > fill_ext) begin
                            status_next = irt_pkg::ST_FILL;
                        end else begin
                            mem_we = 1'b1;
                            if (pos_ext == fill_ext) begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                    end
                    irt_pkg::CMD_REMOVE: begin
                        if (slot_ext >= cap_ext) begin
                            status_next = irt_pkg::ST_CAP;
                            state_next  = S_RESP;
                        end else if (slot_ext >= fill_ext) begin
                            status_next = irt_pkg::ST_FILL;
                            state_next  = S_RESP;
                        end else begin
                            // shift starts at the record after the removed one
                            scan_next  = FILL_W'(slot_ext + CMP_W'(1));
                            state_next = S_SCAN;
                        end
                    end
                    irt_pkg::CMD_FIND, irt_pkg::CMD_LEAST: begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_SCAN: begin
                // issue one read per cycle while entries remain
                if (scan_reg < fill_reg) begin
                    mem_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + FILL_W'(1);
                end

                // consume the entry read in the previous cycle
                if (rd_valid_reg) begin
                    case (cmd_reg)
                        irt_pkg::CMD_REMOVE: begin
                            mem_we      = 1'b1;
                            mem_wr_idx  = rd_addr_reg - IDX_W'(1);
                            mem_wr_data = rd_data_reg;
                        end
                        irt_pkg::CMD_FIND: begin
                            if (!hit_reg && rd_id == key_reg) begin
                                hit_next   = 1'b1;
                                found_next = rd_addr_reg;
                            end
                        end
                        default: begin
                            // least heard: first minimum wins
                            if (rd_addr_reg == '0 || rd_heard < least_reg) begin
                                least_next = rd_heard;
                                found_next = rd_addr_reg;
                            end
                        end
                    endcase
                end

                if (scan_reg >= fill_reg && !rd_valid_reg) begin
                    state_next = S_RESP;
                    case (cmd_reg)
                        irt_pkg::CMD_REMOVE: begin
                            fill_next = fill_reg - FILL_W'(1);
                        end
                        irt_pkg::CMD_FIND: begin
                            if (!hit_reg) begin
                                status_next = irt_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_beat_next.status      = status_reg;
                    m_beat_next.found_index = irt_pkg::FOUND_W'(found_reg);
                    m_beat_next.fill_count  = irt_pkg::FCOUNT_W'(fill_reg);
                    state_next              = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // record memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rec_mem[mem_wr_idx] <= mem_wr_data;
        end
        if (mem_re) begin
            rd_data_reg <= rec_mem[mem_rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg     <= cmd_next;
        slot_reg    <= slot_next;
        key_reg     <= key_next;
        heard_reg   <= heard_next;
        pay_reg     <= pay_next;
        scan_reg    <= scan_next;
        rd_addr_reg <= rd_addr_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        least_reg   <= least_next;
        status_reg  <= status_next;
        m_beat_reg  <= m_beat_next;
    end

endmodule
